// ----- rtl/alst_pkg.sv -----
// ----------------------------------------------------------------------------
// alst_pkg
// Shared widths, constants, codes and controller/datapath types for the
// announce level and speech trigger block.
// ----------------------------------------------------------------------------
package alst_pkg;

  // Number of road classes in the threshold table
  localparam int ROAD_CLASSES = 16;
  localparam int CLASS_W      = (ROAD_CLASSES > 1) ? $clog2(ROAD_CLASSES) : 1;

  // Field widths
  localparam int KIND_W   = 1;
  localparam int ROAD_W   = 5;
  localparam int DIST_W   = 25;
  localparam int ID_W     = 64;
  localparam int THR_W    = 26;
  localparam int LEVEL_W  = 4;
  localparam int LIMIT_W  = 4;

  // Internal widths
  localparam int RD_W        = 26;   // rounded distance, may exceed 25 bits
  localparam int COUNT_W     = 6;    // signed away counter
  localparam int MARK_W      = 27;   // turn-around mark
  localparam int RECIP_W     = 23;   // reciprocal of rounding step
  localparam int STEP_W      = 14;   // rounding step and half step
  localparam int RECIP_SHIFT = 26;   // reciprocal scale 2^26
  localparam int PROD_W      = RD_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // Stream payload widths
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 40;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ROUTE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TABLE = 1'b1;

  // Levels
  localparam logic signed [LEVEL_W-1:0] LEVEL_NONE   = -4'sd2;
  localparam logic signed [LEVEL_W-1:0] LEVEL_BAD    = -4'sd1;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NOW    = 4'sd0;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NEAR   = 4'sd1;
  localparam logic signed [LEVEL_W-1:0] LEVEL_SOON   = 4'sd2;
  localparam logic signed [LEVEL_W-1:0] LEVEL_FOLLOW = 4'sd3;
  localparam logic signed [LEVEL_W-1:0] LEVEL_TURN   = 4'sd4;

  // Other constants
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
  localparam logic [MARK_W-1:0]  MARK_START  = 27'd50;
  localparam logic [MARK_W-1:0]  MARK_FIRST  = 27'd500;
  localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL1,
    ST_MUL2,
    ST_ROUND,
    ST_DECIDE,
    ST_LOOP,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic start;
    logic mul1;
    logic mul2;
    logic round;
    logic decide;
    logic loop_step;
    logic load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic kind;
    logic has;
    logic turn_path;
    logic loop_more;
    logic out_free;
  } status_t;

  // Rounding step selection
  typedef struct packed {
    logic [RECIP_W-1:0] recip;
    logic [STEP_W-1:0]  step;
    logic [STEP_W-1:0]  half;
  } round_step_t;

  // Pick the rounding step for a distance; recip is floor(2^26 / step)
  function automatic round_step_t round_step(input logic [DIST_W-1:0] d);
    round_step_t r;
    if (d < 25'd100) begin
      r = '{recip: 23'd6710886, step: 14'd10, half: 14'd5};
    end else if (d < 25'd250) begin
      r = '{recip: 23'd2684354, step: 14'd25, half: 14'd13};
    end else if (d < 25'd500) begin
      r = '{recip: 23'd1342177, step: 14'd50, half: 14'd25};
    end else if (d < 25'd5000) begin
      r = '{recip: 23'd671088, step: 14'd100, half: 14'd50};
    end else if (d < 25'd100000) begin
      r = '{recip: 23'd67108, step: 14'd1000, half: 14'd500};
    end else begin
      r = '{recip: 23'd6710, step: 14'd10000, half: 14'd5000};
    end
    return r;
  endfunction

endpackage

// ----- rtl/announce_level_and_speech_trigger_top.sv -----
// ----------------------------------------------------------------------------
// announce_level_and_speech_trigger_top
// Route update tracking, maneuver distance rounding, announce level lookup
// and speech trigger, with a per-class threshold table.
// ----------------------------------------------------------------------------
// One item is in work at a time; a finished result sits in the output
// register while the next item is taken. A route update with a maneuver
// goes through capture, update, two multiply steps for rounding,
// correction, level decision and hand-off; the hand-off waits while the
// output register is full. When the turn-around prompt is active, a loop
// step follows the level decision for each doubling of the turn-around
// mark, plus one final step. A table write or an update without a maneuver
// goes through capture, update and hand-off only.
// The configuration write is taken in any cycle and should only be issued
// while no item is in flight.
// ----------------------------------------------------------------------------
module announce_level_and_speech_trigger_top import alst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: road_class[4:0], dest_distance[29:5],
  // maneuver_dest_distance[54:30], has_maneuver[55], maneuver_id[119:56],
  // threshold_now[145:120], threshold_near[171:146],
  // threshold_soon[197:172], zero pad[199:198]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser: kind[0]
  input  logic [KIND_W-1:0]      s_tuser,
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: notify[0], speak[1], level[5:2],
  // rounded_distance[30:6], turning_around[31], write_accepted[32],
  // zero pad[39:33]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration: driving-away limit
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_W-1:0]     cfg_data
);

  // Input field offsets
  localparam int OFS_CLASS = 0;
  localparam int OFS_DEST  = OFS_CLASS + ROAD_W;
  localparam int OFS_MDEST = OFS_DEST + DIST_W;
  localparam int OFS_HAS   = OFS_MDEST + DIST_W;
  localparam int OFS_ID    = OFS_HAS + 1;
  localparam int OFS_NOW   = OFS_ID + ID_W;
  localparam int OFS_NEAR  = OFS_NOW + THR_W;
  localparam int OFS_SOON  = OFS_NEAR + THR_W;
  localparam int OUT_USED  = 3 + LEVEL_W + DIST_W + 1;

  cmd_t    cmd;
  status_t status;

  logic                      out_notify;
  logic                      out_speak;
  logic signed [LEVEL_W-1:0] out_level;
  logic [DIST_W-1:0]         out_rounded_distance;
  logic                      out_turning_around;
  logic                      out_write_accepted;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  alst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  alst_dp u_dp (
    .clk                       (clk),
    .rst                       (rst),
    .cmd                       (cmd),
    .status                    (status),
    .in_kind                   (s_tuser),
    .in_road_class             (s_tdata[OFS_CLASS +: ROAD_W]),
    .in_dest_distance          (s_tdata[OFS_DEST +: DIST_W]),
    .in_maneuver_dest_distance (s_tdata[OFS_MDEST +: DIST_W]),
    .in_has_maneuver           (s_tdata[OFS_HAS]),
    .in_maneuver_id            (s_tdata[OFS_ID +: ID_W]),
    .in_threshold_now          (s_tdata[OFS_NOW +: THR_W]),
    .in_threshold_near         (s_tdata[OFS_NEAR +: THR_W]),
    .in_threshold_soon         (s_tdata[OFS_SOON +: THR_W]),
    .cfg_valid                 (cfg_valid),
    .cfg_data                  (cfg_data),
    .m_tready                  (m_tready),
    .m_tvalid                  (m_tvalid),
    .out_notify                (out_notify),
    .out_speak                 (out_speak),
    .out_level                 (out_level),
    .out_rounded_distance      (out_rounded_distance),
    .out_turning_around        (out_turning_around),
    .out_write_accepted        (out_write_accepted)
  );

  // Pack the result
  assign m_tdata = {{(OUT_TDATA_W-OUT_USED){1'b0}}, out_write_accepted, out_turning_around,
                    out_rounded_distance, out_level, out_speak, out_notify};

endmodule

// ----- rtl/alst_ctrl.sv -----
// ----------------------------------------------------------------------------
// alst_ctrl
// Sequencer: takes one item, steps the datapath through update, rounding,
// level decision and turn-mark iterations, then hands off the result.
// ----------------------------------------------------------------------------
module alst_ctrl import alst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        if (status.kind == KIND_TABLE || !status.has) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.turn_path ? ST_LOOP : ST_DONE;
      end
      ST_LOOP: begin
        cmd.loop_step = 1'b1;
        if (!status.loop_more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/alst_dp.sv -----
// ----------------------------------------------------------------------------
// alst_dp
// Datapath: input capture, away counter, distance rounding by reciprocal
// multiply, threshold table, level and speech decision, turn-mark doubling
// and the output register.
// ----------------------------------------------------------------------------
module alst_dp import alst_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  // Input item fields
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [ROAD_W-1:0]          in_road_class,
  input  logic [DIST_W-1:0]          in_dest_distance,
  input  logic [DIST_W-1:0]          in_maneuver_dest_distance,
  input  logic                       in_has_maneuver,
  input  logic [ID_W-1:0]            in_maneuver_id,
  input  logic signed [THR_W-1:0]    in_threshold_now,
  input  logic signed [THR_W-1:0]    in_threshold_near,
  input  logic signed [THR_W-1:0]    in_threshold_soon,
  // Configuration write
  input  logic                       cfg_valid,
  input  logic [LIMIT_W-1:0]         cfg_data,
  // Result register
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic                       out_notify,
  output logic                       out_speak,
  output logic signed [LEVEL_W-1:0]  out_level,
  output logic [DIST_W-1:0]          out_rounded_distance,
  output logic                       out_turning_around,
  output logic                       out_write_accepted
);

  // Captured item
  logic [KIND_W-1:0]       kind;
  logic [ROAD_W-1:0]       road_class;
  logic [DIST_W-1:0]       dest;
  logic [DIST_W-1:0]       mdest;
  logic                    has;
  logic [ID_W-1:0]         man_id;
  logic signed [THR_W-1:0] thr_now;
  logic signed [THR_W-1:0] thr_near;
  logic signed [THR_W-1:0] thr_soon;

  // Persistent state
  logic [LIMIT_W-1:0]          limit;
  logic [COUNT_W-1:0]          away_count;
  logic                        last_valid;
  logic [DIST_W-1:0]           last_dest;
  logic signed [LEVEL_W-1:0]   last_level;
  logic [MARK_W-1:0]           turn_mark;
  logic [ID_W-1:0]             last_id;
  logic signed [THR_W-1:0]     tab_now  [ROAD_CLASSES];
  logic signed [THR_W-1:0]     tab_near [ROAD_CLASSES];
  logic signed [THR_W-1:0]     tab_soon [ROAD_CLASSES];
  logic [ROAD_CLASSES-1:0]     tab_valid;

  // Rounding pipeline
  logic [RD_W-1:0]    x_val;
  logic [STEP_W-1:0]  step;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [RD_W-1:0]    qs;
  logic [RD_W-1:0]    rd;

  // Registered table read for the current class
  logic signed [THR_W-1:0]   t_now, t_near, t_soon;

  // Working result
  logic                      res_notify;
  logic                      res_speak;
  logic signed [LEVEL_W-1:0] res_level;
  logic                      res_turning;
  logic                      res_write;

  // Combinational helpers
  logic                      class_ok;
  logic [CLASS_W-1:0]        class_idx;
  logic signed [COUNT_W:0]   cnt_ext, cnt_step, lim_ext, lo_ext, cnt_clamped;
  logic                      going_away;
  logic signed [RD_W:0]      diff;
  logic [DIST_W-1:0]         man_dist;
  round_step_t               rs;
  logic [QUOT_W+STEP_W-1:0]  qs_full;
  logic [RD_W-1:0]           rem;
  logic [RD_W-1:0]           step_ext;
  logic signed [RD_W:0]      rd_s;
  logic signed [LEVEL_W-1:0] lvl;
  logic                      turn_path, near_path, id_changed, lvl_drop;
  logic                      loop_more;
  logic [MARK_W-1:0]         mark_next;

  // Class range and table index
  assign class_ok  = ({1'b0, road_class} < (ROAD_W+1)'(ROAD_CLASSES));
  assign class_idx = road_class[CLASS_W-1:0];

  // Away counter step and clamp to [1 - limit, limit]
  assign going_away  = last_valid && (dest > last_dest);
  assign cnt_ext     = {away_count[COUNT_W-1], away_count};
  assign lim_ext     = {{(COUNT_W+1-LIMIT_W){1'b0}}, limit};
  assign lo_ext      = (COUNT_W+1)'(1) - lim_ext;
  assign cnt_step    = going_away ? cnt_ext + (COUNT_W+1)'(1) : cnt_ext - (COUNT_W+1)'(1);
  assign cnt_clamped = (cnt_step > lim_ext) ? lim_ext :
                       (cnt_step < lo_ext)  ? lo_ext  : cnt_step;

  // Maneuver distance, clamped at zero, and its rounding step
  assign diff     = {2'b00, dest} - {2'b00, mdest};
  assign man_dist = diff[RD_W] ? '0 : diff[DIST_W-1:0];
  assign rs       = round_step(man_dist);

  // Quotient times step and one correction step
  assign qs_full  = prod[PROD_W-1:RECIP_SHIFT] * step;
  assign step_ext = {{(RD_W-STEP_W){1'b0}}, step};
  assign rem      = x_val - qs;

  assign rd_s   = {1'b0, rd};

  // Announce level from the first threshold the distance falls under
  always_comb begin
    if (!class_ok) begin
      lvl = LEVEL_BAD;
    end else if (rd_s <= $signed({t_now[THR_W-1], t_now})) begin
      lvl = LEVEL_NOW;
    end else if (rd_s <= $signed({t_near[THR_W-1], t_near})) begin
      lvl = LEVEL_NEAR;
    end else if (rd_s <= $signed({t_soon[THR_W-1], t_soon})) begin
      lvl = LEVEL_SOON;
    end else begin
      lvl = LEVEL_FOLLOW;
    end
  end

  // Branch decisions
  assign turn_path  = (limit != '0) && (cnt_ext == lim_ext);
  assign near_path  = (limit == '0) || (cnt_ext == lo_ext);
  assign id_changed = (man_id != last_id);
  assign lvl_drop   = (lvl < last_level);
  assign loop_more  = ({1'b0, rd} > turn_mark);
  assign mark_next  = (turn_mark >= MARK_FIRST) ? {turn_mark[MARK_W-2:0], 1'b0} : MARK_FIRST;

  // Status to the controller
  assign status.kind      = kind;
  assign status.has       = has;
  assign status.turn_path = turn_path;
  assign status.loop_more = loop_more;
  assign status.out_free  = !m_tvalid || m_tready;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind       <= in_kind;
      road_class <= in_road_class;
      dest       <= in_dest_distance;
      mdest      <= in_maneuver_dest_distance;
      has        <= in_has_maneuver;
      man_id     <= in_maneuver_id;
      thr_now    <= in_threshold_now;
      thr_near   <= in_threshold_near;
      thr_soon   <= in_threshold_soon;
    end
  end

  // Threshold table payload
  always_ff @(posedge clk) begin
    if (cmd.start && kind == KIND_TABLE && class_ok) begin
      tab_now[class_idx]  <= thr_now;
      tab_near[class_idx] <= thr_near;
      tab_soon[class_idx] <= thr_soon;
    end
  end

  // Table read; entries never written read as all minus one
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      t_now  <= tab_valid[class_idx] ? tab_now[class_idx]  : '1;
      t_near <= tab_valid[class_idx] ? tab_near[class_idx] : '1;
      t_soon <= tab_valid[class_idx] ? tab_soon[class_idx] : '1;
    end
  end

  // Control state: limit, counter, history, marks, table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      away_count <= '0;
      last_valid <= 1'b0;
      last_level <= LEVEL_NONE;
      turn_mark  <= MARK_START;
      last_id    <= '0;
      tab_valid  <= '0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (cmd.start) begin
        if (kind == KIND_TABLE) begin
          if (class_ok) begin
            tab_valid[class_idx] <= 1'b1;
          end
        end else begin
          away_count <= cnt_clamped[COUNT_W-1:0];
          last_valid <= 1'b1;
        end
      end
      if (cmd.decide && !turn_path && near_path) begin
        turn_mark <= MARK_START;
        if (id_changed) begin
          last_id <= man_id;
        end
        if (id_changed || lvl_drop) begin
          last_level <= lvl;
        end
      end
      if (cmd.loop_step && loop_more) begin
        turn_mark  <= mark_next;
        last_level <= LEVEL_TURN;
      end
    end
  end

  // Last destination distance
  always_ff @(posedge clk) begin
    if (cmd.start && kind == KIND_ROUTE) begin
      last_dest <= dest;
    end
  end

  // Rounding: add half step, multiply by reciprocal, back-multiply, correct
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_val <= {1'b0, man_dist} + {{(RD_W-STEP_W){1'b0}}, rs.half};
      step  <= rs.step;
      recip <= rs.recip;
    end
    if (cmd.mul1) begin
      prod <= x_val * recip;
    end
    if (cmd.mul2) begin
      qs <= qs_full[RD_W-1:0];
    end
    if (cmd.round) begin
      rd <= (rem >= step_ext) ? qs + step_ext : qs;
    end
  end

  // Working result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_notify  <= (kind == KIND_ROUTE) && has;
      res_speak   <= 1'b0;
      res_level   <= LEVEL_NOW;
      res_turning <= 1'b0;
      res_write   <= (kind == KIND_TABLE) && class_ok;
    end
    if (cmd.decide) begin
      if (turn_path) begin
        res_turning <= 1'b1;
      end else if (near_path) begin
        res_level <= lvl;
        res_speak <= id_changed || lvl_drop;
      end
    end
    if (cmd.loop_step && loop_more) begin
      res_level <= LEVEL_TURN;
      res_speak <= 1'b1;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload; rounded distance saturates at 25 bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_notify         <= res_notify;
      out_speak          <= res_speak;
      out_level          <= res_level;
      out_turning_around <= res_turning;
      out_write_accepted <= res_write;
      if (!res_notify) begin
        out_rounded_distance <= '0;
      end else if (rd > {1'b0, DIST_MAX}) begin
        out_rounded_distance <= DIST_MAX;
      end else begin
        out_rounded_distance <= rd[DIST_W-1:0];
      end
    end
  end

endmodule

// ----- tb/guidance_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// guidance_checker
// Watches the update, result and limit channels of the announce level and
// speech trigger block, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module guidance_checker import alst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // road_class, dest_distance, maneuver_dest_distance, has_maneuver,
  // maneuver_id, threshold_now, threshold_near, threshold_soon, pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // notify, speak, level, rounded_distance, turning_around, write_accepted,
  // pad
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [LIMIT_W-1:0]     cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     results,
  output int                     prompts,
  output int                     turn_results
);

  localparam int REPORT_MAX = 10;

  typedef struct {
    logic                      notify;
    logic                      speak;
    logic signed [LEVEL_W-1:0] level;
    logic [DIST_W-1:0]         rounded;
    logic                      turning;
    logic                      written;
  } guidance_t;

  // Shadow of the block's state and its limit register
  int              thresholds [ROAD_CLASSES][3];
  int              away_count;
  int              prev_level;
  int              prev_dest;
  longint          mark;
  logic [ID_W-1:0] prev_id;
  int              away_limit;
  guidance_t       pending_guidance [$];

  // Round half up in steps that grow with range
  function automatic longint round_meters(input longint d);
    if (d < 100) return (d + 5) / 10 * 10;
    if (d < 250) return (d + 13) / 25 * 25;
    if (d < 500) return (d + 25) / 50 * 50;
    if (d < 5000) return (d + 50) / 100 * 100;
    if (d < 100000) return (d + 500) / 1000 * 1000;
    return (d + 5000) / 10000 * 10000;
  endfunction

  // First threshold the distance falls under picks the level
  function automatic int class_level(input int cls, input longint rd);
    if (cls >= ROAD_CLASSES) return int'(LEVEL_BAD);
    for (int i = 0; i < 3; i++) begin
      if (rd <= longint'(thresholds[cls][i])) return int'(LEVEL_NOW) + i;
    end
    return int'(LEVEL_FOLLOW);
  endfunction

  // Advance the shadow state by one item and return the result it causes
  function automatic guidance_t predict_guidance(input logic [KIND_W-1:0] kind,
                                                 input logic [IN_TDATA_W-1:0] d);
    guidance_t       g;
    int              cls;
    int              dest;
    int              mdest;
    logic [ID_W-1:0] id;
    longint          man_dist;
    longint          rd;
    int              lvl;
    logic            talk;
    g.notify  = 1'b0;
    g.speak   = 1'b0;
    g.level   = LEVEL_NOW;
    g.rounded = '0;
    g.turning = 1'b0;
    g.written = 1'b0;
    cls   = int'(d[4:0]);
    dest  = int'(d[29:5]);
    mdest = int'(d[54:30]);
    id    = d[119:56];

    // Table write: out-of-range classes are dropped
    if (kind == KIND_TABLE) begin
      if (cls < ROAD_CLASSES) begin
        thresholds[cls][0] = int'($signed(d[145:120]));
        thresholds[cls][1] = int'($signed(d[171:146]));
        thresholds[cls][2] = int'($signed(d[197:172]));
        g.written = 1'b1;
      end
      return g;
    end

    // Saturating driving-away counter
    if (dest > prev_dest && prev_dest >= 0) away_count++;
    else away_count--;
    if (away_count > away_limit) away_count = away_limit;
    else if (away_count < 1 - away_limit) away_count = 1 - away_limit;
    prev_dest = dest;
    if (!d[55]) return g;

    man_dist = longint'(dest) - longint'(mdest);
    if (man_dist < 0) man_dist = 0;
    rd   = round_meters(man_dist);
    lvl  = int'(LEVEL_NOW);
    talk = 1'b0;

    if (away_limit != 0 && away_count == away_limit) begin
      // Turn around: prompt each time the mark is passed, then raise or double it
      g.turning = 1'b1;
      while (rd > mark) begin
        prev_level = int'(LEVEL_TURN);
        lvl        = int'(LEVEL_TURN);
        talk       = 1'b1;
        if (mark >= longint'(MARK_FIRST)) mark = mark * 2;
        else mark = longint'(MARK_FIRST);
      end
    end else if (away_limit == 0 || away_count == 1 - away_limit) begin
      // Approaching: speak on a level drop or a new maneuver
      mark = longint'(MARK_START);
      lvl  = class_level(cls, rd);
      if (lvl < prev_level) begin
        prev_level = lvl;
        talk       = 1'b1;
      end
      if (id != prev_id) begin
        prev_id = id;
        talk    = 1'b1;
      end
    end
    if (talk) prev_level = lvl;

    g.notify  = 1'b1;
    g.speak   = talk;
    g.level   = LEVEL_W'(lvl);
    g.rounded = (rd > longint'(DIST_MAX)) ? DIST_MAX : rd[DIST_W-1:0];
    return g;
  endfunction

  always @(posedge clk) begin : watch
    guidance_t got;
    guidance_t want;
    if (rst) begin
      // Power-on state
      for (int c = 0; c < ROAD_CLASSES; c++) begin
        for (int i = 0; i < 3; i++) thresholds[c][i] = -1;
      end
      away_count   = 0;
      prev_level   = int'(LEVEL_NONE);
      prev_dest    = -2;
      mark         = longint'(MARK_START);
      prev_id      = '0;
      away_limit   = int'(LIMIT_RESET);
      mismatches   = 0;
      results      = 0;
      prompts      = 0;
      turn_results = 0;
      pending_guidance.delete();
    end else begin
      // Compare a result transfer with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.notify  = m_tdata[0];
        got.speak   = m_tdata[1];
        got.level   = m_tdata[5:2];
        got.rounded = m_tdata[30:6];
        got.turning = m_tdata[31];
        got.written = m_tdata[32];
        results++;
        if (got.speak) prompts++;
        if (got.turning) turn_results++;
        if (pending_guidance.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("guidance_checker: %0t result with nothing pending: %h", $time, m_tdata);
        end else begin
          want = pending_guidance.pop_front();
          if (got.notify !== want.notify || got.speak !== want.speak ||
              got.level !== want.level || got.rounded !== want.rounded ||
              got.turning !== want.turning || got.written !== want.written) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $write("guidance_checker: %0t mismatch notify/speak/level/dist/turn/wr",
                     $time);
              $display(" exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                       want.notify, want.speak, want.level, want.rounded,
                       want.turning, want.written, got.notify, got.speak, got.level,
                       got.rounded, got.turning, got.written);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) away_limit = int'(cfg_data);
      if (s_tvalid && s_tready) pending_guidance.push_back(predict_guidance(s_tuser, s_tdata));
    end
    outstanding <= pending_guidance.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives route updates and threshold table writes into the announce level
// block under random idling on both sides, steps the turn-around limit
// between phases and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import alst_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int MAX_IDLE        = 12;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int HOLDOFF_AT      = 300;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SENDER          = 0;
  localparam int RECEIVER        = 1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [KIND_W-1:0]      s_tuser   = KIND_ROUTE;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_data  = LIMIT_RESET;

  int mismatches;
  int outstanding;
  int results;
  int prompts;
  int turn_results;

  int items_sent     = 0;
  int table_writes   = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  int burst_left [2] = '{0, 0};

  // Current simulated trip toward the next maneuver
  int                trip_dest  = -1;
  int                trip_mdest = 0;
  int                trip_span  = 1000;
  int                away_run   = 0;
  logic [ID_W-1:0]   trip_id    = '0;
  logic [ROAD_W-1:0] trip_cls   = '0;

  int round_sweep [11] = '{100000, 99999, 5000, 4999, 500, 499, 250, 249, 100, 99, 0};
  int phase_limit [PHASES] = '{0, 15, 1, 2, 7, 3, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  announce_level_and_speech_trigger_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  guidance_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results      (results),
    .prompts      (prompts),
    .turn_results (turn_results)
  );

  // Draw the wait before the next transfer; bursts run with no gaps
  function automatic int idle_cycles(input int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] route_word(input logic [ROAD_W-1:0] cls,
                                                       input logic [DIST_W-1:0] dest,
                                                       input logic [DIST_W-1:0] mdest,
                                                       input logic has,
                                                       input logic [ID_W-1:0] id);
    logic [IN_TDATA_W-1:0] w;
    w         = '0;
    w[4:0]    = cls;
    w[29:5]   = dest;
    w[54:30]  = mdest;
    w[55]     = has;
    w[119:56] = id;
    return w;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] table_word(input logic [ROAD_W-1:0] cls,
                                                       input logic [THR_W-1:0] now,
                                                       input logic [THR_W-1:0] near,
                                                       input logic [THR_W-1:0] soon);
    logic [IN_TDATA_W-1:0] w;
    w          = '0;
    w[4:0]     = cls;
    w[145:120] = now;
    w[171:146] = near;
    w[197:172] = soon;
    return w;
  endfunction

  // Mostly the ordered bound, sometimes never-match or any bit pattern
  function automatic logic [THR_W-1:0] pick_threshold(input int ordered);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return THR_W'($urandom);
    return THR_W'(ordered);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic push_item(input logic [KIND_W-1:0] kind,
                           input logic [IN_TDATA_W-1:0] word);
    int gap;
    gap = idle_cycles(SENDER);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (kind == KIND_TABLE) table_writes++;
  endtask

  // Let the block drain, then load a new turn-around limit
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One random item: table writes, noise, or the next step of a trip
  task automatic random_item();
    int pick;
    int r;
    int top;
    int now;
    int near;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      now  = $urandom_range(0, 300);
      near = now + $urandom_range(0, 3000);
      push_item(KIND_TABLE,
                table_word(($urandom_range(0, 7) == 0) ? ROAD_W'($urandom_range(16, 31))
                                                       : ROAD_W'($urandom_range(0, 15)),
                           pick_threshold(now), pick_threshold(near),
                           pick_threshold(near + $urandom_range(0, 100000))));
    end else if (pick < 15) begin
      push_item(KIND_ROUTE, route_word(ROAD_W'($urandom), DIST_W'($urandom),
                                       DIST_W'($urandom), 1'($urandom), {$urandom, $urandom}));
    end else begin
      // Start a new leg once the maneuver point is passed
      if (trip_dest < trip_mdest || $urandom_range(0, 49) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 4) trip_span = $urandom_range(20, 600);
        else if (r < 7) trip_span = $urandom_range(600, 6000);
        else if (r < 9) trip_span = $urandom_range(6000, 200000);
        else trip_span = $urandom_range(200000, 33000000);
        top        = int'(DIST_MAX) - trip_span;
        trip_mdest = $urandom_range(0, (top < 100000) ? top : 100000);
        trip_dest  = trip_mdest + trip_span;
        trip_id    = {$urandom, $urandom};
        trip_cls   = ($urandom_range(0, 9) == 0) ? ROAD_W'($urandom_range(16, 31))
                                                 : ROAD_W'($urandom_range(0, 15));
        away_run   = 0;
      end
      // Drive away for a stretch, otherwise close in
      if (away_run > 0) begin
        trip_dest += $urandom_range(1, trip_span / 8 + 1);
        if (trip_dest > int'(DIST_MAX)) trip_dest = int'(DIST_MAX);
        away_run--;
      end else begin
        if ($urandom_range(0, 24) == 0) away_run = $urandom_range(2, 36);
        trip_dest -= $urandom_range(0, trip_span / 5 + 1);
        if (trip_dest < 0) trip_dest = 0;
      end
      push_item(KIND_ROUTE, route_word(trip_cls, DIST_W'(trip_dest), DIST_W'(trip_mdest),
                                       $urandom_range(0, 14) != 0, trip_id));
    end
  endtask

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random readiness plus one long hold-off
  initial begin : take_results
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (taken == HOLDOFF_AT) ? HOLDOFF_CYCLES : idle_cycles(RECEIVER);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: first update has no maneuver, then a bad road class
    push_item(KIND_ROUTE, route_word(5'd0, 25'd33000000, 25'd0, 1'b0, 64'd0));
    push_item(KIND_ROUTE, route_word(5'd31, 25'd32000000, 25'd31999900, 1'b1, 64'd1));
    push_item(KIND_ROUTE, route_word(5'd31, 25'd31000000, 25'd30999800, 1'b1, 64'd1));

    // Table writes, in range, at the extremes and out of range
    push_item(KIND_TABLE, table_word(5'd0, 26'd100, 26'd500, 26'd2000));
    push_item(KIND_TABLE, table_word(5'd15, 26'h1FFFFFF, 26'h1FFFFFF, 26'h1FFFFFF));
    push_item(KIND_TABLE, table_word(5'd16, 26'd5, 26'd5, 26'd5));
    push_item(KIND_TABLE, table_word(5'd31, '1, '1, '1));
    push_item(KIND_TABLE, table_word(5'd1, {1'b1, 25'd0}, '1, 26'd0));

    // Approach across every rounding step; levels drop on the way in
    for (int i = 0; i < 11; i++)
      push_item(KIND_ROUTE, route_word(5'd0, DIST_W'(30000000 - 10 * i),
                                       DIST_W'(30000000 - 10 * i - round_sweep[i]),
                                       1'b1, 64'd2));

    // Maneuver point behind the position: distance clamps to zero
    push_item(KIND_ROUTE, route_word(5'd1, 25'd29000000, 25'd29000500, 1'b1, 64'd2));

    // Drive away at full range until the turn-around prompt fires
    for (int i = 0; i < 5; i++)
      push_item(KIND_ROUTE, route_word(5'd15, DIST_W'(33554427 + i), 25'd0, 1'b1, 64'd3));

    // Random phases, each under its own limit
    for (int p = 0; p < PHASES; p++) begin
      write_limit((p == PHASES - 1) ? LIMIT_W'($urandom_range(0, 15))
                                    : LIMIT_W'(phase_limit[p]));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end
    s_tvalid <= 1'b0;

    // Drain and report
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d items (%0d table writes) under %0d limit values, %0d results",
             items_sent, table_writes, settings_used + 1, results);
    $display("tb_top: %0d spoken prompts, %0d turn-around results, %0d mismatches",
             prompts, turn_results, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/alst_pkg.sv
rtl/alst_ctrl.sv
rtl/alst_dp.sv
rtl/announce_level_and_speech_trigger_top.sv
tb/guidance_checker.sv
tb/tb_top.sv
